@@ hdl/ddim_pkg.sv @@
`default_nettype none
package ddim_pkg;

  // defaults for the top level parameters
  localparam int NUM_REGS_DEF      = 64;
  localparam int MAX_BLOCK_LEN_DEF = 1024;

  // fixed field widths
  localparam int REG_MASK_W = 64;
  localparam int NUM_FLAGS  = 5;
  localparam int CNT_OUT_W  = 11;
  localparam int CP_OUT_W   = 11;
  localparam int ILP_OUT_W  = 20;
  localparam int WGT_OUT_W  = 30;
  localparam int TOTAL_W    = 64;

  // ilp scaling
  localparam int MILLI   = 1000;
  localparam int MILLI_W = 10;

  // register levels are reduced in groups of this size
  localparam int GROUP_SIZE = 8;

  // depth of the queue between front and core
  localparam int QUEUE_DEPTH = 2;

  // one classified instruction word
  typedef struct packed {
    logic [REG_MASK_W-1:0] read_mask;
    logic [REG_MASK_W-1:0] write_mask;
    logic                  mem_read;
    logic                  mem_write;
    logic [NUM_FLAGS-1:0]  flags_rd;
    logic [NUM_FLAGS-1:0]  flags_wr;
    logic                  last;
  } instr_t;

endpackage
`default_nettype wire

@@ hdl/ddim_front.sv @@
`default_nettype none
module ddim_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  input  wire logic [ddim_pkg::REG_MASK_W-1:0]     src_mask,
  input  wire logic [ddim_pkg::REG_MASK_W-1:0]     dst_mask,
  input  wire logic                                touches_mem,
  input  wire logic                                writes_mem,
  input  wire logic [ddim_pkg::NUM_FLAGS-1:0]      flags_rd,
  input  wire logic [ddim_pkg::NUM_FLAGS-1:0]      flags_wr,
  input  wire logic                                last,
  output logic                                     full,
  output ddim_pkg::instr_t                         head,
  output logic                                     head_valid,
  input  wire logic                                pop
);

  localparam int QD = ddim_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  ddim_pkg::instr_t q_r [QD];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  ddim_pkg::instr_t word_in;

  // classify: written registers count as read, a memory write touches memory
  always_comb begin
    word_in.read_mask  = src_mask | dst_mask;
    word_in.write_mask = dst_mask;
    word_in.mem_read   = touches_mem | writes_mem;
    word_in.mem_write  = writes_mem;
    word_in.flags_rd   = flags_rd;
    word_in.flags_wr   = flags_wr;
    word_in.last       = last;
  end

  assign full       = (cnt_r == CW'(QD));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= word_in;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QD - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QD - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/ddim_core.sv @@
`default_nettype none
module ddim_core #(
  parameter int NUM_REGS      = ddim_pkg::NUM_REGS_DEF,
  parameter int MAX_BLOCK_LEN = ddim_pkg::MAX_BLOCK_LEN_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ddim_pkg::instr_t                      head,
  input  wire logic                                  head_valid,
  output logic                                       pop,
  input  wire logic                                  fin_busy,
  output logic                                       blk_go,
  output logic [$clog2(MAX_BLOCK_LEN+1)-1:0]         blk_count,
  output logic [$clog2(MAX_BLOCK_LEN+1)-1:0]         blk_max,
  output logic                                       blk_ovf
);

  localparam int CW = $clog2(MAX_BLOCK_LEN + 1);
  localparam int GS = ddim_pkg::GROUP_SIZE;
  localparam int NG = (NUM_REGS + GS - 1) / GS;
  localparam int NF = ddim_pkg::NUM_FLAGS;

  localparam logic PH_LOOK   = 1'b0;
  localparam logic PH_COMMIT = 1'b1;

  logic                phase_r;
  logic [CW-1:0]       reg_level_r  [NUM_REGS];
  logic [CW-1:0]       mem_level_r;
  logic [CW-1:0]       flag_level_r [NF];
  logic [CW-1:0]       max_level_r;
  logic [CW-1:0]       block_count_r;
  logic                block_ovf_r;

  logic [CW-1:0]       grp_max_r    [NG];
  logic [CW-1:0]       grp_max_nxt  [NG];
  logic [CW-1:0]       side_max_r;
  logic [CW-1:0]       side_max_nxt;
  logic [NUM_REGS-1:0] dst_r;
  logic                wmem_r;
  logic [NF-1:0]       fw_r;
  logic                last_r;

  logic [CW-1:0]       lvl_pad [NG*GS];
  logic [NG*GS-1:0]    rd_pad;
  logic [CW-1:0]       ic;
  logic [CW:0]         ic_inc;
  logic [CW-1:0]       nl;
  logic                cnt_full;
  logic                commit;

  // pad the register file out to whole groups
  for (genvar k = 0; k < NG*GS; k++) begin : g_pad
    if (k < NUM_REGS) begin : g_live
      assign lvl_pad[k] = reg_level_r[k];
      assign rd_pad[k]  = head.read_mask[k];
    end else begin : g_zero
      assign lvl_pad[k] = '0;
      assign rd_pad[k]  = 1'b0;
    end
  end

  // first half: per-group maxima of the levels touched
  always_comb begin
    logic [CW-1:0] m;
    for (int g = 0; g < NG; g++) begin
      m = '0;
      for (int j = 0; j < GS; j++) begin
        if (rd_pad[g*GS+j] && (lvl_pad[g*GS+j] > m)) begin
          m = lvl_pad[g*GS+j];
        end
      end
      grp_max_nxt[g] = m;
    end
  end

  // first half: memory token and flags
  always_comb begin
    side_max_nxt = head.mem_read ? mem_level_r : '0;
    for (int f = 0; f < NF; f++) begin
      if (head.flags_rd[f] && (flag_level_r[f] > side_max_nxt)) begin
        side_max_nxt = flag_level_r[f];
      end
    end
  end

  // second half: issue level and the level written back
  always_comb begin
    ic = side_max_r;
    for (int g = 0; g < NG; g++) begin
      if (grp_max_r[g] > ic) begin
        ic = grp_max_r[g];
      end
    end
    ic_inc = {1'b0, ic} + (CW+1)'(1);
    nl     = (ic_inc > (CW+1)'(MAX_BLOCK_LEN)) ? CW'(MAX_BLOCK_LEN) : ic_inc[CW-1:0];
  end

  assign cnt_full  = (block_count_r >= CW'(MAX_BLOCK_LEN));
  assign pop       = (phase_r == PH_LOOK) && head_valid;
  assign commit    = (phase_r == PH_COMMIT) && (!last_r || !fin_busy);
  assign blk_go    = commit && last_r;
  assign blk_count = cnt_full ? block_count_r : block_count_r + CW'(1);
  assign blk_max   = (ic > max_level_r) ? ic : max_level_r;
  assign blk_ovf   = block_ovf_r | cnt_full;

  // captured word for the second half
  always_ff @(posedge clk) begin
    if (pop) begin
      grp_max_r  <= grp_max_nxt;
      side_max_r <= side_max_nxt;
      dst_r      <= head.write_mask[NUM_REGS-1:0];
      wmem_r     <= head.mem_write;
      fw_r       <= head.flags_wr;
      last_r     <= head.last;
    end
  end

  // level tracking, cleared at the end of every block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LOOK;
      mem_level_r   <= '0;
      max_level_r   <= '0;
      block_count_r <= '0;
      block_ovf_r   <= 1'b0;
      for (int k = 0; k < NUM_REGS; k++) begin
        reg_level_r[k] <= '0;
      end
      for (int f = 0; f < NF; f++) begin
        flag_level_r[f] <= '0;
      end
    end else begin
      case (phase_r)
        PH_LOOK: begin
          if (head_valid) begin
            phase_r <= PH_COMMIT;
          end
        end
        PH_COMMIT: begin
          if (commit) begin
            phase_r <= PH_LOOK;
            if (last_r) begin
              mem_level_r   <= '0;
              max_level_r   <= '0;
              block_count_r <= '0;
              block_ovf_r   <= 1'b0;
              for (int k = 0; k < NUM_REGS; k++) begin
                reg_level_r[k] <= '0;
              end
              for (int f = 0; f < NF; f++) begin
                flag_level_r[f] <= '0;
              end
            end else begin
              max_level_r   <= blk_max;
              block_count_r <= blk_count;
              block_ovf_r   <= blk_ovf;
              if (wmem_r) begin
                mem_level_r <= nl;
              end
              for (int k = 0; k < NUM_REGS; k++) begin
                if (dst_r[k]) begin
                  reg_level_r[k] <= nl;
                end
              end
              for (int f = 0; f < NF; f++) begin
                if (fw_r[f]) begin
                  flag_level_r[f] <= nl;
                end
              end
            end
          end
        end
        default: begin
          phase_r <= PH_LOOK;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/ddim_finish.sv @@
`default_nettype none
module ddim_finish #(
  parameter int MAX_BLOCK_LEN = ddim_pkg::MAX_BLOCK_LEN_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  go,
  input  wire logic [$clog2(MAX_BLOCK_LEN+1)-1:0]    blk_count,
  input  wire logic [$clog2(MAX_BLOCK_LEN+1)-1:0]    blk_max,
  input  wire logic                                  blk_ovf,
  output logic                                       busy,
  output logic                                       res_valid,
  output logic [ddim_pkg::CNT_OUT_W-1:0]             res_count,
  output logic [ddim_pkg::CP_OUT_W-1:0]              res_cp,
  output logic [ddim_pkg::ILP_OUT_W-1:0]             res_ilp,
  output logic [ddim_pkg::WGT_OUT_W-1:0]             res_wgt,
  output logic [ddim_pkg::TOTAL_W-1:0]               res_total_ins,
  output logic [ddim_pkg::TOTAL_W-1:0]               res_total_wgt,
  output logic                                       res_ovf
);

  localparam int CW = $clog2(MAX_BLOCK_LEN + 1);
  localparam int NW = CW + ddim_pkg::MILLI_W;
  localparam int WW = NW + CW;
  localparam int IW = $clog2(NW);
  localparam int TW = ddim_pkg::TOTAL_W;

  localparam logic [2:0] FS_IDLE = 3'd0;
  localparam logic [2:0] FS_PREP = 3'd1;
  localparam logic [2:0] FS_DIV  = 3'd2;
  localparam logic [2:0] FS_MUL  = 3'd3;
  localparam logic [2:0] FS_SUM  = 3'd4;

  logic [2:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] max_r;
  logic          ovf_r;
  logic [CW-1:0] cp_r;
  logic [NW-1:0] num_r;
  logic [CW:0]   rem_r;
  logic [IW-1:0] it_r;
  logic [WW-1:0] wgt_r;
  logic [TW-1:0] sum_ins_r;
  logic [TW-1:0] sum_wgt_r;
  logic          valid_r;

  logic [CW:0]   mp1;
  logic [CW-1:0] cp_a;
  logic [CW-1:0] cp_b;
  logic [CW-1:0] cp_nxt;
  logic [CW:0]   rem_sh;
  logic          ge;

  // critical path: max level plus one, limited by the block length and count, at least one
  always_comb begin
    mp1    = {1'b0, max_r} + (CW+1)'(1);
    cp_a   = (mp1 > (CW+1)'(MAX_BLOCK_LEN)) ? CW'(MAX_BLOCK_LEN) : mp1[CW-1:0];
    cp_b   = (cp_a > cnt_r) ? cnt_r : cp_a;
    cp_nxt = (cp_b == '0) ? CW'(1) : cp_b;
  end

  // one restoring divide step per cycle, quotient shifts into num_r
  assign rem_sh = {rem_r[CW-1:0], num_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, cp_r});

  assign busy          = (st_r != FS_IDLE);
  assign res_valid     = valid_r;
  assign res_count     = ddim_pkg::CNT_OUT_W'(cnt_r);
  assign res_cp        = ddim_pkg::CP_OUT_W'(cp_r);
  assign res_ilp       = ddim_pkg::ILP_OUT_W'(num_r);
  assign res_wgt       = ddim_pkg::WGT_OUT_W'(wgt_r);
  assign res_total_ins = sum_ins_r;
  assign res_total_wgt = sum_wgt_r;
  assign res_ovf       = ovf_r;

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      FS_IDLE: begin
        if (go) begin
          cnt_r <= blk_count;
          max_r <= blk_max;
          ovf_r <= blk_ovf;
        end
      end
      FS_PREP: begin
        cp_r  <= cp_nxt;
        num_r <= NW'(cnt_r) * NW'(ddim_pkg::MILLI);
        rem_r <= '0;
        it_r  <= IW'(NW - 1);
      end
      FS_DIV: begin
        rem_r <= ge ? rem_sh - {1'b0, cp_r} : rem_sh;
        num_r <= {num_r[NW-2:0], ge};
        it_r  <= it_r - IW'(1);
      end
      FS_MUL: begin
        wgt_r <= WW'(num_r) * WW'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  // sequencer, running totals and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= FS_IDLE;
      sum_ins_r <= '0;
      sum_wgt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= (st_r == FS_SUM);
      case (st_r)
        FS_IDLE: begin
          if (go) begin
            st_r <= FS_PREP;
          end
        end
        FS_PREP: begin
          st_r <= FS_DIV;
        end
        FS_DIV: begin
          if (it_r == '0) begin
            st_r <= FS_MUL;
          end
        end
        FS_MUL: begin
          st_r <= FS_SUM;
        end
        FS_SUM: begin
          sum_ins_r <= sum_ins_r + TW'(cnt_r);
          sum_wgt_r <= sum_wgt_r + TW'(wgt_r);
          st_r      <= FS_IDLE;
        end
        default: begin
          st_r <= FS_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dataflow_depth_ilp_meter.sv @@
`default_nettype none
// Dataflow depth / ILP meter.
// Input: one decoded instruction word is taken at a rising edge with start
// high and busy low. The word carries the registers, memory token and flags
// the instruction reads and writes, and a mark for the last word of a block.
// Words go into a two-word queue; the core takes one word in two steps,
// the first reducing the touched levels in groups of eight, the second
// finishing the maximum and writing the new levels back. busy is high while
// the queue is full.
// Output: on the last word of a block one result word is shown with
// out_valid high for exactly one cycle. After the last word leaves the
// queue, the finisher prepares the operands, runs the one-bit-per-cycle
// divider for count * 1000 / critical path, then the weight multiply and
// the running sums, and registers the strobe. A following block's last
// word waits in the core until the finisher is idle again; earlier words
// of it flow on.
// The receiver cannot stall: each result is taken in its strobe cycle.
// Reset (rst_n low, synchronous) empties the queue, clears all levels and
// block counts and zeroes the running totals.
module dataflow_depth_ilp_meter #(
  parameter int NUM_REGS      = ddim_pkg::NUM_REGS_DEF,
  parameter int MAX_BLOCK_LEN = ddim_pkg::MAX_BLOCK_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ddim_pkg::REG_MASK_W-1:0]     in_src_reg_mask,
  input  wire logic [ddim_pkg::REG_MASK_W-1:0]     in_dst_reg_mask,
  input  wire logic                                in_touches_memory,
  input  wire logic                                in_writes_memory,
  input  wire logic [ddim_pkg::NUM_FLAGS-1:0]      in_flags_read,
  input  wire logic [ddim_pkg::NUM_FLAGS-1:0]      in_flags_written,
  input  wire logic                                in_last_in_block,
  output logic                                     out_valid,
  output logic [ddim_pkg::CNT_OUT_W-1:0]           out_instr_count,
  output logic [ddim_pkg::CP_OUT_W-1:0]            out_critical_path,
  output logic [ddim_pkg::ILP_OUT_W-1:0]           out_ilp_milli,
  output logic [ddim_pkg::WGT_OUT_W-1:0]           out_weighted_ilp,
  output logic [ddim_pkg::TOTAL_W-1:0]             out_total_instructions,
  output logic [ddim_pkg::TOTAL_W-1:0]             out_total_weighted,
  output logic                                     out_overflowed
);

  localparam int CW = $clog2(MAX_BLOCK_LEN + 1);

  ddim_pkg::instr_t head;
  logic             head_valid;
  logic             pop;
  logic             push;
  logic             fin_busy;
  logic             blk_go;
  logic [CW-1:0]    blk_count;
  logic [CW-1:0]    blk_max;
  logic             blk_ovf;

  assign push = start && !busy;

  // front: accept and classify into the queue
  ddim_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .src_mask    (in_src_reg_mask),
    .dst_mask    (in_dst_reg_mask),
    .touches_mem (in_touches_memory),
    .writes_mem  (in_writes_memory),
    .flags_rd    (in_flags_read),
    .flags_wr    (in_flags_written),
    .last        (in_last_in_block),
    .full        (busy),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  // core: per-block level tracking
  ddim_core #(
    .NUM_REGS      (NUM_REGS),
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .fin_busy   (fin_busy),
    .blk_go     (blk_go),
    .blk_count  (blk_count),
    .blk_max    (blk_max),
    .blk_ovf    (blk_ovf)
  );

  // block summary: divide, weight, totals
  ddim_finish #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
  ) u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (blk_go),
    .blk_count     (blk_count),
    .blk_max       (blk_max),
    .blk_ovf       (blk_ovf),
    .busy          (fin_busy),
    .res_valid     (out_valid),
    .res_count     (out_instr_count),
    .res_cp        (out_critical_path),
    .res_ilp       (out_ilp_milli),
    .res_wgt       (out_weighted_ilp),
    .res_total_ins (out_total_instructions),
    .res_total_wgt (out_total_weighted),
    .res_ovf       (out_overflowed)
  );

  // a result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a block summary is handed over only to an idle finisher
  a_handover_idle: assert property (@(posedge clk) disable iff (!rst_n)
    blk_go |-> !fin_busy)
    else $error("block summary handed to a busy finisher");

  // critical path is non-zero and never exceeds the count
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (MAX_BLOCK_LEN > 2047) ||
      ((out_critical_path != '0) && (out_critical_path <= out_instr_count)))
    else $error("critical path out of range");

endmodule
`default_nettype wire

@@ bench/ddim_checker.sv @@
module ddim_checker #(
  parameter int NUM_REGS      = ddim_pkg::NUM_REGS_DEF,
  parameter int MAX_BLOCK_LEN = ddim_pkg::MAX_BLOCK_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [ddim_pkg::REG_MASK_W-1:0]     in_src_reg_mask,
  input  logic [ddim_pkg::REG_MASK_W-1:0]     in_dst_reg_mask,
  input  logic                                in_touches_memory,
  input  logic                                in_writes_memory,
  input  logic [ddim_pkg::NUM_FLAGS-1:0]      in_flags_read,
  input  logic [ddim_pkg::NUM_FLAGS-1:0]      in_flags_written,
  input  logic                                in_last_in_block,
  input  logic                                out_valid,
  input  logic [ddim_pkg::CNT_OUT_W-1:0]      out_instr_count,
  input  logic [ddim_pkg::CP_OUT_W-1:0]       out_critical_path,
  input  logic [ddim_pkg::ILP_OUT_W-1:0]      out_ilp_milli,
  input  logic [ddim_pkg::WGT_OUT_W-1:0]      out_weighted_ilp,
  input  logic [ddim_pkg::TOTAL_W-1:0]        out_total_instructions,
  input  logic [ddim_pkg::TOTAL_W-1:0]        out_total_weighted,
  input  logic                                out_overflowed,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ddim_pkg::*;

  localparam int LVL_W = $clog2(MAX_BLOCK_LEN + 1);

  // figures of one finished basic block
  typedef struct {
    logic [CNT_OUT_W-1:0] count;
    logic [CP_OUT_W-1:0]  path;
    logic [ILP_OUT_W-1:0] ilp;
    logic [WGT_OUT_W-1:0] weighted;
    logic [TOTAL_W-1:0]   total_instr;
    logic [TOTAL_W-1:0]   total_wgt;
    logic                 overflow;
  } block_stats_t;

  // per-block ready levels and running totals
  logic [LVL_W-1:0]   reg_ready [NUM_REGS];
  logic [LVL_W-1:0]   mem_ready;
  logic [LVL_W-1:0]   flag_ready [NUM_FLAGS];
  logic [LVL_W-1:0]   deepest;
  logic [LVL_W-1:0]   blk_len;
  logic               blk_ovf;
  logic [TOTAL_W-1:0] sum_instr;
  logic [TOTAL_W-1:0] sum_wgt;

  block_stats_t stats_due [$];
  block_stats_t seen;

  initial errors = 0;

  task automatic clear_levels();
    for (int i = 0; i < NUM_REGS; i++) reg_ready[i] = '0;
    for (int i = 0; i < NUM_FLAGS; i++) flag_ready[i] = '0;
    mem_ready = '0;
    deepest   = '0;
    blk_len   = '0;
    blk_ovf   = 1'b0;
  endtask

  // issue level of one word, level write-back, block figures on the last word
  task automatic account_instr(
    input logic [REG_MASK_W-1:0] src,
    input logic [REG_MASK_W-1:0] dst,
    input logic                  touch_mem,
    input logic                  write_mem,
    input logic [NUM_FLAGS-1:0]  frd,
    input logic [NUM_FLAGS-1:0]  fwr,
    input logic                  last
  );
    logic [REG_MASK_W-1:0] touched;
    logic [LVL_W-1:0]      issue;
    logic [LVL_W:0]        nxt;
    longint unsigned       cnt;
    longint unsigned       cp;
    longint unsigned       ilp;
    longint unsigned       wgt;
    block_stats_t          st;
    touched = src | dst;
    issue   = '0;
    for (int i = 0; i < NUM_REGS; i++)
      if (touched[i] && reg_ready[i] > issue) issue = reg_ready[i];
    if ((touch_mem || write_mem) && mem_ready > issue) issue = mem_ready;
    for (int i = 0; i < NUM_FLAGS; i++)
      if (frd[i] && flag_ready[i] > issue) issue = flag_ready[i];
    if (issue > deepest) deepest = issue;

    // new level saturates at the block length limit
    nxt = {1'b0, issue} + (LVL_W+1)'(1);
    if (nxt > (LVL_W+1)'(MAX_BLOCK_LEN)) nxt = (LVL_W+1)'(MAX_BLOCK_LEN);
    for (int i = 0; i < NUM_REGS; i++)
      if (dst[i]) reg_ready[i] = nxt[LVL_W-1:0];
    if (write_mem) mem_ready = nxt[LVL_W-1:0];
    for (int i = 0; i < NUM_FLAGS; i++)
      if (fwr[i]) flag_ready[i] = nxt[LVL_W-1:0];

    if (blk_len >= LVL_W'(MAX_BLOCK_LEN)) blk_ovf = 1'b1;
    else blk_len = blk_len + LVL_W'(1);

    if (last) begin
      cnt = 64'(blk_len);
      cp  = 64'(deepest) + 64'd1;
      if (cp > 64'(MAX_BLOCK_LEN)) cp = 64'(MAX_BLOCK_LEN);
      if (cp > cnt) cp = cnt;
      if (cp == 64'd0) cp = 64'd1;
      ilp = (cnt * 64'(MILLI)) / cp;
      wgt = ilp * cnt;
      sum_instr = sum_instr + cnt;
      sum_wgt   = sum_wgt + wgt;
      st.count       = CNT_OUT_W'(cnt);
      st.path        = CP_OUT_W'(cp);
      st.ilp         = ILP_OUT_W'(ilp);
      st.weighted    = WGT_OUT_W'(wgt);
      st.total_instr = sum_instr;
      st.total_wgt   = sum_wgt;
      st.overflow    = blk_ovf;
      stats_due.insert(stats_due.size(), st);
      clear_levels();
    end
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // results are compared before the word of the same edge is accounted
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_levels();
      sum_instr = '0;
      sum_wgt   = '0;
      stats_due.delete();
    end else begin
      if (out_valid) begin
        if (stats_due.size() == 0) begin
          $display("%0t: result word with none expected, instr_count %0d", $time,
                   out_instr_count);
          errors++;
        end else begin
          seen = stats_due.pop_front();
          check_field("instr_count", 64'(seen.count), 64'(out_instr_count));
          check_field("critical_path", 64'(seen.path), 64'(out_critical_path));
          check_field("ilp_milli", 64'(seen.ilp), 64'(out_ilp_milli));
          check_field("weighted_ilp", 64'(seen.weighted), 64'(out_weighted_ilp));
          check_field("total_instructions", seen.total_instr, out_total_instructions);
          check_field("total_weighted", seen.total_wgt, out_total_weighted);
          check_field("overflowed", 64'(seen.overflow), 64'(out_overflowed));
        end
      end
      if (start && !busy)
        account_instr(in_src_reg_mask, in_dst_reg_mask, in_touches_memory,
                      in_writes_memory, in_flags_read, in_flags_written,
                      in_last_in_block);
    end
    pending <= stats_due.size();
  end

endmodule

@@ bench/tb_dataflow_depth_ilp_meter.sv @@
module tb_dataflow_depth_ilp_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import ddim_pkg::*;

  localparam int NREGS      = NUM_REGS_DEF;
  localparam int MAX_LEN    = MAX_BLOCK_LEN_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_WORDS = 650;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [REG_MASK_W-1:0] in_src_reg_mask;
  logic [REG_MASK_W-1:0] in_dst_reg_mask;
  logic                  in_touches_memory;
  logic                  in_writes_memory;
  logic [NUM_FLAGS-1:0]  in_flags_read;
  logic [NUM_FLAGS-1:0]  in_flags_written;
  logic                  in_last_in_block;
  logic                  out_valid;
  logic [CNT_OUT_W-1:0]  out_instr_count;
  logic [CP_OUT_W-1:0]   out_critical_path;
  logic [ILP_OUT_W-1:0]  out_ilp_milli;
  logic [WGT_OUT_W-1:0]  out_weighted_ilp;
  logic [TOTAL_W-1:0]    out_total_instructions;
  logic [TOTAL_W-1:0]    out_total_weighted;
  logic                  out_overflowed;

  int errors;
  int pending;
  int idle_cycles;
  bit burst;

  dataflow_depth_ilp_meter #(
    .NUM_REGS      (NREGS),
    .MAX_BLOCK_LEN (MAX_LEN)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_src_reg_mask        (in_src_reg_mask),
    .in_dst_reg_mask        (in_dst_reg_mask),
    .in_touches_memory      (in_touches_memory),
    .in_writes_memory       (in_writes_memory),
    .in_flags_read          (in_flags_read),
    .in_flags_written       (in_flags_written),
    .in_last_in_block       (in_last_in_block),
    .out_valid              (out_valid),
    .out_instr_count        (out_instr_count),
    .out_critical_path      (out_critical_path),
    .out_ilp_milli          (out_ilp_milli),
    .out_weighted_ilp       (out_weighted_ilp),
    .out_total_instructions (out_total_instructions),
    .out_total_weighted     (out_total_weighted),
    .out_overflowed         (out_overflowed)
  );

  ddim_checker #(
    .NUM_REGS      (NREGS),
    .MAX_BLOCK_LEN (MAX_LEN)
  ) ilp_chk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_src_reg_mask        (in_src_reg_mask),
    .in_dst_reg_mask        (in_dst_reg_mask),
    .in_touches_memory      (in_touches_memory),
    .in_writes_memory       (in_writes_memory),
    .in_flags_read          (in_flags_read),
    .in_flags_written       (in_flags_written),
    .in_last_in_block       (in_last_in_block),
    .out_valid              (out_valid),
    .out_instr_count        (out_instr_count),
    .out_critical_path      (out_critical_path),
    .out_ilp_milli          (out_ilp_milli),
    .out_weighted_ilp       (out_weighted_ilp),
    .out_total_instructions (out_total_instructions),
    .out_total_weighted     (out_total_weighted),
    .out_overflowed         (out_overflowed),
    .errors                 (errors),
    .pending                (pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no word taken and no result shown
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_dataflow_depth_ilp_meter failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int next_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // sparse masks biased to the low registers so chains form
  function automatic logic [REG_MASK_W-1:0] rand_regs();
    logic [REG_MASK_W-1:0] m;
    int n;
    m = '0;
    case ($urandom_range(19))
      0: m = {$urandom, $urandom};
      1: m = '1;
      2, 3: m = '0;
      default: begin
        n = $urandom_range(3, 1);
        for (int k = 0; k < n; k++)
          m[($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  function automatic logic [NUM_FLAGS-1:0] rand_flags();
    case ($urandom_range(5))
      0: return NUM_FLAGS'($urandom_range(31));
      1: return '0;
      default: return NUM_FLAGS'(1) << $urandom_range(NUM_FLAGS - 1);
    endcase
  endfunction

  // lower start and put noise on the fields while idling
  task automatic idle_for(input int n);
    if (n > 0) begin
      start             <= 1'b0;
      in_src_reg_mask   <= {$urandom, $urandom};
      in_dst_reg_mask   <= {$urandom, $urandom};
      in_touches_memory <= 1'($urandom_range(1));
      in_writes_memory  <= 1'($urandom_range(1));
      in_flags_read     <= NUM_FLAGS'($urandom_range(31));
      in_flags_written  <= NUM_FLAGS'($urandom_range(31));
      in_last_in_block  <= 1'($urandom_range(1));
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one word and hold it until taken
  task automatic send_word(
    input logic [REG_MASK_W-1:0] src,
    input logic [REG_MASK_W-1:0] dst,
    input logic                  touch_mem,
    input logic                  write_mem,
    input logic [NUM_FLAGS-1:0]  frd,
    input logic [NUM_FLAGS-1:0]  fwr,
    input logic                  last
  );
    in_src_reg_mask   <= src;
    in_dst_reg_mask   <= dst;
    in_touches_memory <= touch_mem;
    in_writes_memory  <= write_mem;
    in_flags_read     <= frd;
    in_flags_written  <= fwr;
    in_last_in_block  <= last;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
    if (!burst) idle_for(next_gap());
  endtask

  // hold off until every expected result has come
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one basic block with random content; chained words all touch register 7
  task automatic emit_block(input int len, input bit chained);
    logic [REG_MASK_W-1:0] dst;
    for (int k = 0; k < len; k++) begin
      dst = rand_regs();
      if (chained) dst[7] = 1'b1;
      send_word(rand_regs(), dst, 1'($urandom_range(1)), ($urandom_range(3) == 0),
                rand_flags(), rand_flags(), (k == len - 1));
    end
  endtask

  initial begin
    int sent;
    int len;
    int blocks;
    bit long_done;
    rst_n             = 1'b0;
    start             = 1'b0;
    burst             = 1'b0;
    in_src_reg_mask   = '0;
    in_dst_reg_mask   = '0;
    in_touches_memory = 1'b0;
    in_writes_memory  = 1'b0;
    in_flags_read     = '0;
    in_flags_written  = '0;
    in_last_in_block  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-word block with nothing touched
    send_word('0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
    // everything read and written twice: chain of two
    send_word('1, '1, 1'b1, 1'b1, '1, '1, 1'b0);
    send_word('1, '1, 1'b1, 1'b1, '1, '1, 1'b1);
    // memory write without touch mark, then a plain memory read
    send_word('0, '0, 1'b0, 1'b1, '0, '0, 1'b0);
    send_word('0, '0, 1'b1, 1'b0, '0, '0, 1'b1);
    // independent words at the register extremes
    send_word('0, 64'h1, 1'b0, 1'b0, '0, '0, 1'b0);
    send_word('0, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0, '0, 1'b0);
    send_word('0, 64'h0000_0001_0000_0000, 1'b0, 1'b0, '0, '0, 1'b0);
    send_word('0, 64'h2, 1'b0, 1'b0, '0, '0, 1'b1);
    // flag dependency, top flag bit
    send_word('0, '0, 1'b0, 1'b0, '0, 5'b10000, 1'b0);
    send_word('0, '0, 1'b0, 1'b0, 5'b10000, 5'b00001, 1'b0);
    send_word('0, '0, 1'b0, 1'b0, 5'b00001, '0, 1'b1);
    // a written register counts as read
    send_word('0, 64'h20, 1'b0, 1'b0, '0, '0, 1'b0);
    send_word('0, 64'h20, 1'b0, 1'b0, '0, '0, 1'b1);
    // source read on the top register after a write
    send_word('0, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0, '0, 1'b0);
    send_word(64'h8000_0000_0000_0000, '0, 1'b0, 1'b0, '0, '0, 1'b1);
    drain();

    // random blocks, one of them past the length limit with a full chain
    sent      = 0;
    blocks    = 0;
    long_done = 1'b0;
    while (sent < RAND_WORDS) begin
      burst = ($urandom_range(9) < 3);
      if (!long_done && sent >= 300) begin
        emit_block(MAX_LEN + 6, 1'b1);
        sent     += MAX_LEN + 6;
        long_done = 1'b1;
      end
      case ($urandom_range(19))
        0, 1, 2: len = $urandom_range(60, 13);
        default: len = $urandom_range(12, 1);
      endcase
      emit_block(len, ($urandom_range(3) == 0));
      sent   += len;
      blocks += 1;
      if (blocks == 8 || $urandom_range(40) == 0) drain();
    end
    burst = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_dataflow_depth_ilp_meter passed");
    end else begin
      $display("tb_dataflow_depth_ilp_meter failed");
    end
    $finish;
  end

endmodule
